### rtl/gpdc_pkg.sv
package gpdc_pkg;

    // field widths
    localparam int POS_W   = 32;
    localparam int GAIN_W  = 16;
    localparam int CUR_W   = 15;
    localparam int TICK_W  = 16;
    localparam int DRV_W   = 16;

    // configuration port
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int IDX_W   = 3;

    // pd datapath widths
    localparam int ERR_W      = 35;
    localparam int PROD_P_W   = 52;
    localparam int PROD_D_W   = 49;
    localparam int P_SHIFT    = 8;
    localparam int DIFF_W     = PROD_P_W + P_SHIFT;
    localparam int FRAC_SHIFT = 24;

    // what a request does, carried down the pipeline
    typedef logic [1:0] mode_t;
    localparam mode_t MODE_HOME  = 2'd0;
    localparam mode_t MODE_CAPT  = 2'd1;
    localparam mode_t MODE_CLOSE = 2'd2;
    localparam mode_t MODE_PD    = 2'd3;

    // register map
    localparam logic [IDX_W-1:0] REG_GRIP_CUR       = 3'd0;
    localparam logic [IDX_W-1:0] REG_RELEASE_POS    = 3'd1;
    localparam logic [IDX_W-1:0] REG_PROP_GAIN      = 3'd2;
    localparam logic [IDX_W-1:0] REG_DERIV_GAIN     = 3'd3;
    localparam logic [IDX_W-1:0] REG_SEEK_CUR       = 3'd4;
    localparam logic [IDX_W-1:0] REG_HOMING_TICKS   = 3'd5;
    localparam logic [IDX_W-1:0] REG_INVERT_LEFT    = 3'd6;
    localparam logic [IDX_W-1:0] REG_INVERT_RIGHT   = 3'd7;

    // reset values
    localparam logic [CUR_W-1:0]  RST_GRIP_CUR       = 15'd5000;
    localparam logic [POS_W-1:0]  RST_RELEASE_POS    = 32'd3277;
    localparam logic [GAIN_W-1:0] RST_PROP_GAIN      = 16'd6000;
    localparam logic [GAIN_W-1:0] RST_DERIV_GAIN     = 16'd768;
    localparam logic [CUR_W-1:0]  RST_SEEK_CUR       = 15'd500;
    localparam logic [TICK_W-1:0] RST_HOMING_TICKS   = 16'd300;
    localparam logic              RST_INVERT_LEFT    = 1'b0;
    localparam logic              RST_INVERT_RIGHT   = 1'b1;

    // per-stage load enables of the lane pipeline
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } stage_en_t;

endpackage

### rtl/gpdc_lane.sv
module gpdc_lane (
    input  logic                                clk,
    input  gpdc_pkg::stage_en_t                 en,
    input  logic signed [gpdc_pkg::POS_W-1:0]   raw_pos,
    input  logic signed [gpdc_pkg::POS_W-1:0]   vel,
    input  logic signed [gpdc_pkg::POS_W-1:0]   zero_pos,
    input  logic signed [gpdc_pkg::POS_W-1:0]   release_pos,
    input  logic                                invert,
    input  logic        [gpdc_pkg::GAIN_W-1:0]  prop_gain,
    input  logic        [gpdc_pkg::GAIN_W-1:0]  deriv_gain,
    output logic signed [gpdc_pkg::DIFF_W-1:0]  diff
);
    import gpdc_pkg::*;

    logic signed [POS_W-1:0]    raw_reg;
    logic signed [POS_W-1:0]    vel_reg;
    logic signed [POS_W-1:0]    zero_reg;
    logic signed [ERR_W-1:0]    err_reg;
    logic signed [PROD_D_W-1:0] dterm_reg;
    logic signed [PROD_P_W-1:0] pterm_reg;
    logic signed [PROD_D_W-1:0] dterm3_reg;
    logic signed [DIFF_W-1:0]   diff_reg;

    logic signed [ERR_W-1:0]    tgt_ext;
    logic signed [ERR_W-1:0]    tgt_dir;
    logic signed [ERR_W-1:0]    raw_ext;
    logic signed [ERR_W-1:0]    zero_ext;
    logic signed [ERR_W-1:0]    err_next;
    logic signed [PROD_D_W-1:0] dterm_next;
    logic signed [PROD_P_W-1:0] pterm_next;
    logic signed [DIFF_W-1:0]   diff_next;

    // stage 2: position error and derivative product
    assign tgt_ext    = {{(ERR_W-POS_W){release_pos[POS_W-1]}}, release_pos};
    assign tgt_dir    = invert ? -tgt_ext : tgt_ext;
    assign raw_ext    = {{(ERR_W-POS_W){raw_reg[POS_W-1]}}, raw_reg};
    assign zero_ext   = {{(ERR_W-POS_W){zero_reg[POS_W-1]}}, zero_reg};
    assign err_next   = tgt_dir - (raw_ext - zero_ext);
    assign dterm_next = $signed({1'b0, deriv_gain}) * vel_reg;

    // stage 3: proportional product
    assign pterm_next = $signed({1'b0, prop_gain}) * err_reg;

    // stage 4: p in q.24 minus d
    assign diff_next  = $signed({pterm_reg, {P_SHIFT{1'b0}}})
                      - $signed({{(DIFF_W-PROD_D_W){dterm3_reg[PROD_D_W-1]}}, dterm3_reg});

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            raw_reg  <= raw_pos;
            vel_reg  <= vel;
            zero_reg <= zero_pos;
        end
        if (en.s2)
        begin
            err_reg   <= err_next;
            dterm_reg <= dterm_next;
        end
        if (en.s3)
        begin
            pterm_reg  <= pterm_next;
            dterm3_reg <= dterm_reg;
        end
        if (en.s4)
        begin
            diff_reg <= diff_next;
        end
    end

    assign diff = diff_reg;

endmodule

### rtl/gpdc_merge.sv
module gpdc_merge (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                load,
    input  logic                                in_valid,
    input  gpdc_pkg::mode_t                     mode,
    input  logic signed [gpdc_pkg::DIFF_W-1:0]  diff_left,
    input  logic signed [gpdc_pkg::DIFF_W-1:0]  diff_right,
    input  logic        [gpdc_pkg::CUR_W-1:0]   seek_cur,
    input  logic        [gpdc_pkg::CUR_W-1:0]   grip_cur,
    input  logic                                invert_left,
    input  logic                                invert_right,
    output logic                                out_valid,
    output logic signed [gpdc_pkg::DRV_W-1:0]   drive_left,
    output logic signed [gpdc_pkg::DRV_W-1:0]   drive_right,
    output logic                                homing_active
);
    import gpdc_pkg::*;

    logic                     valid_reg;
    logic signed [DRV_W-1:0]  left_reg;
    logic signed [DRV_W-1:0]  right_reg;
    logic                     homing_reg;
    logic signed [DRV_W-1:0]  left_next;
    logic signed [DRV_W-1:0]  right_next;
    logic                     homing_next;
    logic signed [DRV_W-1:0]  hc_ext;
    logic signed [DRV_W-1:0]  cc_ext;

    // round to nearest (ties upward) from q.24, then clamp to 16 bits
    function automatic logic signed [DRV_W-1:0] round_sat(input logic signed [DIFF_W-1:0] v);
        logic signed [DIFF_W:0]            biased;
        logic signed [DIFF_W-FRAC_SHIFT:0] whole;
        logic                              fits;
        biased = $signed({v[DIFF_W-1], v})
               + $signed({{(DIFF_W-FRAC_SHIFT+1){1'b0}}, 1'b1, {(FRAC_SHIFT-1){1'b0}}});
        whole  = biased[DIFF_W:FRAC_SHIFT];
        fits   = (&whole[DIFF_W-FRAC_SHIFT:DRV_W-1]) | ~(|whole[DIFF_W-FRAC_SHIFT:DRV_W-1]);
        if (fits)
            round_sat = whole[DRV_W-1:0];
        else if (whole[DIFF_W-FRAC_SHIFT])
            round_sat = {1'b1, {(DRV_W-1){1'b0}}};
        else
            round_sat = {1'b0, {(DRV_W-1){1'b1}}};
    endfunction

    assign hc_ext = $signed({1'b0, seek_cur});
    assign cc_ext = $signed({1'b0, grip_cur});

    always_comb
    begin
        case (mode)
            MODE_HOME:
            begin
                left_next  = invert_left  ? hc_ext : -hc_ext;
                right_next = invert_right ? hc_ext : -hc_ext;
            end
            MODE_CAPT:
            begin
                left_next  = '0;
                right_next = '0;
            end
            MODE_CLOSE:
            begin
                left_next  = invert_left  ? -cc_ext : cc_ext;
                right_next = invert_right ? -cc_ext : cc_ext;
            end
            MODE_PD:
            begin
                left_next  = round_sat(diff_left);
                right_next = round_sat(diff_right);
            end
            default:
            begin
                left_next  = '0;
                right_next = '0;
            end
        endcase
        homing_next = (mode == MODE_HOME);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            left_reg   <= left_next;
            right_reg  <= right_next;
            homing_reg <= homing_next;
        end
    end

    assign out_valid     = valid_reg;
    assign drive_left    = left_reg;
    assign drive_right   = right_reg;
    assign homing_active = homing_reg;

endmodule

### rtl/gripper_homing_pd_controller.sv
// latency: a result passes the four lane stages and then the output register before it shows on the output
// throughput: one request per cycle unless a full pipeline is held by a stalled output; each
// of the four lane stages and the output register takes a new request every cycle when it is empty or moves on
// a stalled output holds its result while the pipeline keeps filling behind it
// reset: registers take their documented defaults, homing is active, tick count and
// both captured zeros are cleared, and the pipeline is emptied
module gripper_homing_pd_controller (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic        [gpdc_pkg::ADDR_W-1:0]  paddr,
    input  logic        [gpdc_pkg::DATA_W-1:0]  pwdata,
    output logic        [gpdc_pkg::DATA_W-1:0]  prdata,
    output logic                                pready,
    // request channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [gpdc_pkg::POS_W-1:0]   raw_pos_left,
    input  logic signed [gpdc_pkg::POS_W-1:0]   raw_pos_right,
    input  logic signed [gpdc_pkg::POS_W-1:0]   vel_left,
    input  logic signed [gpdc_pkg::POS_W-1:0]   vel_right,
    input  logic                                open_req,
    // result channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [gpdc_pkg::DRV_W-1:0]   drive_left,
    output logic signed [gpdc_pkg::DRV_W-1:0]   drive_right,
    output logic                                homing_active
);
    import gpdc_pkg::*;

    // configuration registers
    logic        [CUR_W-1:0]  grip_cur_reg;
    logic signed [POS_W-1:0]  release_pos_reg;
    logic        [GAIN_W-1:0] prop_gain_reg;
    logic        [GAIN_W-1:0] deriv_gain_reg;
    logic        [CUR_W-1:0]  seek_cur_reg;
    logic        [TICK_W-1:0] homing_ticks_reg;
    logic                     invert_left_reg;
    logic                     invert_right_reg;

    logic                     cfg_wr;
    logic        [IDX_W-1:0]  cfg_idx;

    // homing state
    logic                     homing_reg;
    logic        [TICK_W-1:0] tick_reg;
    logic signed [POS_W-1:0]  zero_left_reg;
    logic signed [POS_W-1:0]  zero_right_reg;
    logic        [TICK_W-1:0] tick_next;
    mode_t                    mode_next;
    logic                     accept;

    // pipeline sideband: valid and mode per stage, stage 1 at index 0
    logic        [3:0]        vld_reg;
    mode_t                    mode_reg [4];
    stage_en_t                take;
    logic                     take_out;

    logic signed [DIFF_W-1:0] diff_left;
    logic signed [DIFF_W-1:0] diff_right;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grip_cur_reg       <= RST_GRIP_CUR;
            release_pos_reg    <= RST_RELEASE_POS;
            prop_gain_reg      <= RST_PROP_GAIN;
            deriv_gain_reg     <= RST_DERIV_GAIN;
            seek_cur_reg       <= RST_SEEK_CUR;
            homing_ticks_reg   <= RST_HOMING_TICKS;
            invert_left_reg    <= RST_INVERT_LEFT;
            invert_right_reg   <= RST_INVERT_RIGHT;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_GRIP_CUR:       grip_cur_reg       <= pwdata[CUR_W-1:0];
                REG_RELEASE_POS:    release_pos_reg    <= pwdata[POS_W-1:0];
                REG_PROP_GAIN:      prop_gain_reg      <= pwdata[GAIN_W-1:0];
                REG_DERIV_GAIN:     deriv_gain_reg     <= pwdata[GAIN_W-1:0];
                REG_SEEK_CUR:       seek_cur_reg       <= pwdata[CUR_W-1:0];
                REG_HOMING_TICKS:   homing_ticks_reg   <= pwdata[TICK_W-1:0];
                REG_INVERT_LEFT:    invert_left_reg    <= pwdata[0];
                REG_INVERT_RIGHT:   invert_right_reg   <= pwdata[0];
                default:            ;
            endcase
        end
    end

    // register readback, zero-extended
    always_comb
    begin
        case (cfg_idx)
            REG_GRIP_CUR:       prdata = {{(DATA_W-CUR_W){1'b0}}, grip_cur_reg};
            REG_RELEASE_POS:    prdata = release_pos_reg;
            REG_PROP_GAIN:      prdata = {{(DATA_W-GAIN_W){1'b0}}, prop_gain_reg};
            REG_DERIV_GAIN:     prdata = {{(DATA_W-GAIN_W){1'b0}}, deriv_gain_reg};
            REG_SEEK_CUR:       prdata = {{(DATA_W-CUR_W){1'b0}}, seek_cur_reg};
            REG_HOMING_TICKS:   prdata = {{(DATA_W-TICK_W){1'b0}}, homing_ticks_reg};
            REG_INVERT_LEFT:    prdata = {{(DATA_W-1){1'b0}}, invert_left_reg};
            REG_INVERT_RIGHT:   prdata = {{(DATA_W-1){1'b0}}, invert_right_reg};
            default:            prdata = '0;
        endcase
    end

    // ---------------- pipeline flow control ----------------
    // a stage can load when it is empty or the stage after it moves on, so
    // bubbles collapse and the input keeps flowing while the output waits, until the pipeline is full
    assign take_out = ~out_valid | ~out_stall;
    assign take.s4  = ~vld_reg[3] | take_out;
    assign take.s3  = ~vld_reg[2] | take.s4;
    assign take.s2  = ~vld_reg[1] | take.s3;
    assign take.s1  = ~vld_reg[0] | take.s2;

    assign in_stall = ~take.s1;
    assign accept   = in_valid & take.s1;

    // ---------------- homing sequencer ----------------
    // the whole homing decision is made as the request enters, so the next
    // request already sees the updated count, flag and zeros
    assign tick_next = (tick_reg == {TICK_W{1'b1}}) ? tick_reg : tick_reg + 1'b1;

    always_comb
    begin
        if (homing_reg)
            mode_next = (tick_next < homing_ticks_reg) ? MODE_HOME : MODE_CAPT;
        else
            mode_next = open_req ? MODE_PD : MODE_CLOSE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            homing_reg     <= 1'b1;
            tick_reg       <= '0;
            zero_left_reg  <= '0;
            zero_right_reg <= '0;
        end
        else if (accept && homing_reg)
        begin
            tick_reg <= tick_next;
            // capture tick: this request's raw positions become the zeros
            if (mode_next == MODE_CAPT)
            begin
                zero_left_reg  <= raw_pos_left;
                zero_right_reg <= raw_pos_right;
                homing_reg     <= 1'b0;
            end
        end
    end

    // ---------------- sideband pipeline ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (take.s1)
                vld_reg[0] <= in_valid;
            if (take.s2)
                vld_reg[1] <= vld_reg[0];
            if (take.s3)
                vld_reg[2] <= vld_reg[1];
            if (take.s4)
                vld_reg[3] <= vld_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (take.s1)
            mode_reg[0] <= mode_next;
        if (take.s2)
            mode_reg[1] <= mode_reg[0];
        if (take.s3)
            mode_reg[2] <= mode_reg[1];
        if (take.s4)
            mode_reg[3] <= mode_reg[2];
    end

    // ---------------- motor lanes ----------------
    // one pd core per motor, identical and running in lockstep
    gpdc_lane u_lane_left (
        .clk         (clk),
        .en          (take),
        .raw_pos     (raw_pos_left),
        .vel         (vel_left),
        .zero_pos    (zero_left_reg),
        .release_pos (release_pos_reg),
        .invert      (invert_left_reg),
        .prop_gain   (prop_gain_reg),
        .deriv_gain  (deriv_gain_reg),
        .diff        (diff_left)
    );

    gpdc_lane u_lane_right (
        .clk         (clk),
        .en          (take),
        .raw_pos     (raw_pos_right),
        .vel         (vel_right),
        .zero_pos    (zero_right_reg),
        .release_pos (release_pos_reg),
        .invert      (invert_right_reg),
        .prop_gain   (prop_gain_reg),
        .deriv_gain  (deriv_gain_reg),
        .diff        (diff_right)
    );

    // ---------------- merge and output register ----------------
    // picks homing, capture, close or pd drive per request and rounds and clamps the pd terms
    gpdc_merge u_merge (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (take_out),
        .in_valid       (vld_reg[3]),
        .mode           (mode_reg[3]),
        .diff_left      (diff_left),
        .diff_right     (diff_right),
        .seek_cur       (seek_cur_reg),
        .grip_cur       (grip_cur_reg),
        .invert_left    (invert_left_reg),
        .invert_right   (invert_right_reg),
        .out_valid      (out_valid),
        .drive_left     (drive_left),
        .drive_right    (drive_right),
        .homing_active  (homing_active)
    );

endmodule

### rtl/gpdc_checker.sv
module gpdc_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic signed [gpdc_pkg::DRV_W-1:0]   drive_left,
    input  logic signed [gpdc_pkg::DRV_W-1:0]   drive_right,
    input  logic                                homing_active
);
    import gpdc_pkg::*;

    logic done_reg;

    // set once a result leaving homing has been delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else if (out_valid && !out_stall && !homing_active)
            done_reg <= 1'b1;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(drive_left)
                                   && $stable(drive_right) && $stable(homing_active))
        else $error("stalled result changed");

    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with output register empty");

    a_homing_once: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && out_valid |-> !homing_active)
        else $error("homing resumed after it ended");

    a_homing_drive_mag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && homing_active && in_valid |->
            (drive_left == drive_right) || (DRV_W'(drive_left + drive_right) == '0))
        else $error("homing drives differ in magnitude");

endmodule

bind gripper_homing_pd_controller gpdc_checker u_gpdc_checker (.*);
